/* hdl/pdce_pkg.sv */
// ----------------------------------------------------------------------------
// pdce_pkg
// Shared widths, constants, handshake structs and the zigzag map for the
// polyline delta character encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pdce_pkg;

    localparam int LAT_W   = 25;
    localparam int LNG_W   = 26;
    localparam int DELTA_W = 27;   // exact difference of two 26-bit values
    localparam int ZZ_W    = DELTA_W + 1;
    localparam int CHUNK_W = 5;
    localparam int CHAR_W  = 7;
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_BIAS  = 7'd63;
    localparam logic [CHAR_W-1:0] CHUNK_MORE = 7'h20;

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new point, update previous point
        logic emit;      // write one character into the output register
        logic sel_lng;   // 0: latitude value, 1: longitude value
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a character this cycle
        logic last_chunk;  // selected value has at most five bits left
    } t_sts;

    // shift left, invert when negative
    function automatic logic [ZZ_W-1:0] zigzag(input logic [DELTA_W-1:0] d);
        zigzag = {d, 1'b0} ^ {ZZ_W{d[DELTA_W-1]}};
    endfunction

endpackage

`default_nettype wire

/* hdl/pdce_ctrl.sv */
// ----------------------------------------------------------------------------
// pdce_ctrl
// Sequencer: takes one point, then walks the latitude and the longitude
// characters out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module pdce_ctrl
    import pdce_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_in_emitted,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LAT  = 2'd1;
    localparam logic [1:0] S_LNG  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.load    = o_in_ready && i_in_valid && i_in_emitted;
        o_cmd.emit    = ((r_state == S_LAT) || (r_state == S_LNG)) && i_sts.out_free;
        o_cmd.sel_lng = (r_state == S_LNG);
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_LAT;
                end
            end
            S_LAT: begin
                if (o_cmd.emit && i_sts.last_chunk) begin
                    n_state = S_LNG;
                end
            end
            S_LNG: begin
                if (o_cmd.emit && i_sts.last_chunk) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_starts_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_LAT))
        else $error("load did not start the latitude characters");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_cmd.emit)
        else $error("load and emit in the same cycle");

    a_lng_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.sel_lng && i_sts.last_chunk) |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after the last character");

endmodule

`default_nettype wire

/* hdl/pdce_dp.sv */
// ----------------------------------------------------------------------------
// pdce_dp
// Datapath: previous point, delta and zigzag, chunk shifters and the output
// character register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdce_dp
    import pdce_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [LAT_W-1:0]  i_lat_e5,
    input  wire  [LNG_W-1:0]  i_lng_e5,
    input  wire               i_first_point,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [CHAR_W-1:0] o_code_char,
    output logic              o_item_done
);

    logic [LAT_W-1:0]   r_prev_lat;
    logic [LNG_W-1:0]   r_prev_lng;
    logic [ZZ_W-1:0]    r_z_lat;
    logic [ZZ_W-1:0]    r_z_lng;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_done;

    logic [LAT_W-1:0]   base_lat;
    logic [LNG_W-1:0]   base_lng;
    logic [DELTA_W-1:0] d_lat;
    logic [DELTA_W-1:0] d_lng;
    logic [ZZ_W-1:0]    z_sel;
    logic               more;
    logic [CHAR_W-1:0]  n_char;

    always_comb begin
        base_lat = i_first_point ? '0 : r_prev_lat;
        base_lng = i_first_point ? '0 : r_prev_lng;
        d_lat = {{(DELTA_W-LAT_W){i_lat_e5[LAT_W-1]}}, i_lat_e5}
              - {{(DELTA_W-LAT_W){base_lat[LAT_W-1]}}, base_lat};
        d_lng = {{(DELTA_W-LNG_W){i_lng_e5[LNG_W-1]}}, i_lng_e5}
              - {{(DELTA_W-LNG_W){base_lng[LNG_W-1]}}, base_lng};
        z_sel  = i_cmd.sel_lng ? r_z_lng : r_z_lat;
        more   = |z_sel[ZZ_W-1:CHUNK_W];
        n_char = ({{(CHAR_W-CHUNK_W){1'b0}}, z_sel[CHUNK_W-1:0]}
                 | (more ? CHUNK_MORE : '0)) + CHAR_BIAS;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.last_chunk = !more;
    end

    // point state and chunk shifters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_lat <= '0;
            r_prev_lng <= '0;
        end else if (i_cmd.load) begin
            r_prev_lat <= i_lat_e5;
            r_prev_lng <= i_lng_e5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z_lat <= zigzag(d_lat);
            r_z_lng <= zigzag(d_lng);
        end else if (i_cmd.emit) begin
            if (i_cmd.sel_lng) begin
                r_z_lng <= r_z_lng >> CHUNK_W;
            end else begin
                r_z_lat <= r_z_lat >> CHUNK_W;
            end
        end
    end

    // output character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_done <= i_cmd.sel_lng && !more;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code_char = r_char;
    assign o_item_done = r_done;

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("character written over a pending one");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.sel_lng && o_sts.last_chunk) |=> (r_out_valid && r_done))
        else $error("final longitude character not flagged");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_char >= CHAR_BIAS))
        else $error("character below bias");

endmodule

`default_nettype wire

/* hdl/polyline_delta_char_encoder_unit.sv */
// ----------------------------------------------------------------------------
// polyline_delta_char_encoder_unit
// Encoded polyline point encoder: delta against the previous emitted point,
// zigzag map, five-bit chunks to printable characters.
//
//   channel   dir  data                             sideband
//   s_axis    in   [24:0] lat_e5, [50:25] lng_e5     tuser: kept, first_point
//                                                    tlast: last_point
//   m_axis    out  [6:0] code_char                   tlast: item_done
//
// an emitted point is loaded, then its characters (2 to 12) are written
// one at a time by the chunk shifters, each when the output register is
// free. a point with no flag set is dropped.
// reset is synchronous active low and clears the previous point to zero.
// a stalled m_axis holds the character; the shifter waits on the output
// register, and the next point is taken while the last character waits.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_delta_char_encoder_unit
    import pdce_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,   // lat_e5, lng_e5, zero pad
    input  wire  [IN_USER_W-1:0]  s_axis_tuser,   // kept, first_point
    input  wire                   s_axis_tlast,   // last_point
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // code_char, zero pad
    output logic                  m_axis_tlast    // item_done
);

    t_cmd              cmd;
    t_sts              sts;
    logic              emitted;
    logic [CHAR_W-1:0] code_char;

    assign emitted = s_axis_tuser[0] | s_axis_tuser[1] | s_axis_tlast;

    pdce_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_emitted (emitted),
        .o_in_ready   (s_axis_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    pdce_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lat_e5      (s_axis_tdata[LAT_W-1:0]),
        .i_lng_e5      (s_axis_tdata[LAT_W+LNG_W-1:LAT_W]),
        .i_first_point (s_axis_tuser[1]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_code_char   (code_char),
        .o_item_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-CHAR_W){1'b0}}, code_char};

endmodule

`default_nettype wire

/* verif/polyline_delta_char_encoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// polyline_delta_char_encoder_unit_tb
// Self-checking bench for the polyline point encoder. Points go in on s_axis.
// A scoreboard forms the delta against the last emitted point, applies the
// zigzag map and splits the result into characters. Every beat on m_axis is
// checked against the oldest queued character. Flag combinations, field
// extremes and a well-known three-point line come first. Random polylines
// follow under several idle and stall mixes, then a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_delta_char_encoder_unit_tb;

    import pdce_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int LAT_SPAN      = 9_000_000;
    localparam int LNG_SPAN      = 18_000_000;
    localparam int PAD_W         = IN_DATA_W - LAT_W - LNG_W;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              item_done;
    } t_enc_char;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // lat_e5, lng_e5, zero pad
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // kept, first_point
    logic                  s_axis_tlast = 1'b0; // last_point
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // code_char, zero pad
    logic                  m_axis_tlast;        // item_done

    t_enc_char               expected_chars[$];
    logic signed [LAT_W-1:0] last_lat;
    logic signed [LNG_W-1:0] last_lng;
    int unsigned             tx_idle_pct = 0;
    int unsigned             rx_stall_pct = 0;
    logic                    rx_hold = 1'b0;
    int                      mismatch_count = 0;

    polyline_delta_char_encoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // characters of one signed delta, low chunk first
    function automatic void queue_delta_chars(input logic signed [DELTA_W-1:0] delta);
        logic [ZZ_W-1:0] zz;
        t_enc_char       c;
        zz = {delta, 1'b0};
        if (delta[DELTA_W-1])
            zz = ~zz;
        c.item_done = 1'b0;
        while (zz >= ZZ_W'(CHUNK_MORE)) begin
            c.code_char = (CHUNK_MORE | {2'b00, zz[CHUNK_W-1:0]}) + CHAR_BIAS;
            expected_chars.push_back(c);
            zz = zz >> CHUNK_W;
        end
        c.code_char = {2'b00, zz[CHUNK_W-1:0]} + CHAR_BIAS;
        expected_chars.push_back(c);
    endfunction

    function automatic void encode_point(input logic [LAT_W-1:0] lat,
                                         input logic [LNG_W-1:0] lng,
                                         input logic kept, input logic is_first,
                                         input logic is_last);
        logic signed [DELTA_W-1:0] dlat;
        logic signed [DELTA_W-1:0] dlng;
        t_enc_char                 tail;
        if (!(kept || is_first || is_last))
            return;
        if (is_first) begin
            last_lat = '0;
            last_lng = '0;
        end
        dlat = {{2{lat[LAT_W-1]}}, lat} - {{2{last_lat[LAT_W-1]}}, last_lat};
        dlng = {lng[LNG_W-1], lng} - {last_lng[LNG_W-1], last_lng};
        queue_delta_chars(dlat);
        queue_delta_chars(dlng);
        tail = expected_chars.pop_back();
        tail.item_done = 1'b1;
        expected_chars.push_back(tail);
        last_lat = lat;
        last_lng = lng;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %0d: %s expected %0d got %0d", mismatch_count, what, want, got);
    endtask

    always @(posedge i_clk) begin : check_beat
        t_enc_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected beat, code_char", -1, m_axis_tdata[CHAR_W-1:0]);
            end else begin
                want = expected_chars.pop_front();
                if (m_axis_tdata[CHAR_W-1:0] !== want.code_char)
                    report_mismatch("code_char", want.code_char, m_axis_tdata[CHAR_W-1:0]);
                if (m_axis_tlast !== want.item_done)
                    report_mismatch("item_done", want.item_done, m_axis_tlast);
            end
        end
    end

    // drives one point and waits for its accepting edge
    task automatic send_point(input logic [LAT_W-1:0] lat, input logic [LNG_W-1:0] lng,
                              input logic kept, input logic is_first, input logic is_last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, lng, lat};
        s_axis_tuser  <= {is_first, kept};
        s_axis_tlast  <= is_last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        encode_point(lat, lng, kept, is_first, is_last);
    endtask

    function automatic int step_coord(input int cur, input int span);
        case ($urandom_range(9))
            0:       return int'($urandom);
            1, 2:    return int'($urandom_range(2 * span)) - span;
            3, 4:    return cur + int'($urandom_range(32)) - 16;
            5:       return cur + int'($urandom_range(4000)) - 2000;
            default: return cur + int'($urandom_range(400000)) - 200000;
        endcase
    endfunction

    task automatic test_flag_combinations();
        send_point(25'd0, 26'd0, 1'b0, 1'b1, 1'b0);          // zero delta after first
        send_point(25'd100, 26'd200, 1'b0, 1'b0, 1'b0);      // dropped
        send_point(25'd0, 26'd0, 1'b1, 1'b0, 1'b0);          // zero delta, kept
        send_point(25'd5, -26'sd7, 1'b0, 1'b0, 1'b1);
        send_point(-25'sd3, 26'd9, 1'b1, 1'b1, 1'b1);
        send_point(-25'sd3, 26'd9, 1'b0, 1'b1, 1'b1);
        send_point(25'd17, 26'd33, 1'b1, 1'b0, 1'b1);
        send_point(25'h1ffffff, 26'h3ffffff, 1'b0, 1'b0, 1'b0); // dropped, all ones
        send_point(25'd18, 26'd32, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_value_extremes();
        send_point(25'sd9000000, 26'sd18000000, 1'b0, 1'b1, 1'b0);
        send_point(-25'sd9000000, -26'sd18000000, 1'b1, 1'b0, 1'b0);
        send_point(25'sd9000000, 26'sd18000000, 1'b0, 1'b0, 1'b1);
        // raw bit extremes give the widest deltas
        send_point(25'h1000000, 26'h2000000, 1'b0, 1'b1, 1'b0);
        send_point(25'h0ffffff, 26'h1ffffff, 1'b1, 1'b0, 1'b0);
        send_point(25'h1000000, 26'h2000000, 1'b1, 1'b0, 1'b0);
        send_point(25'h0ffffff, 26'h1ffffff, 1'b0, 1'b1, 1'b1);
        send_point(25'h1ffffff, 26'h3ffffff, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_known_polyline();
        send_point(25'sd3850000, -26'sd12020000, 1'b1, 1'b1, 1'b0);
        send_point(25'sd4070000, -26'sd12095000, 1'b1, 1'b0, 1'b0);
        send_point(25'sd4325200, -26'sd12645300, 1'b1, 1'b0, 1'b1);
    endtask

    // mostly well-formed lines, some lines with arbitrary flags
    task automatic test_random_polylines(input int point_goal);
        int   sent_count;
        int   seg_len;
        int   k;
        int   cur_lat;
        int   cur_lng;
        logic noisy;
        logic kept;
        logic is_first;
        logic is_last;
        sent_count = 0;
        cur_lat = 0;
        cur_lng = 0;
        while (sent_count < point_goal) begin
            seg_len = int'($urandom_range(12, 1));
            noisy   = ($urandom_range(99) < 15);
            for (k = 0; k < seg_len; k++) begin
                cur_lat = step_coord(cur_lat, LAT_SPAN);
                cur_lng = step_coord(cur_lng, LNG_SPAN);
                if (noisy) begin
                    kept     = 1'($urandom_range(1));
                    is_first = 1'($urandom_range(1));
                    is_last  = 1'($urandom_range(1));
                end else begin
                    kept     = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(9) < 7);
                    is_first = (k == 0);
                    is_last  = (k == seg_len - 1);
                end
                send_point(cur_lat[LAT_W-1:0], cur_lng[LNG_W-1:0], kept, is_first, is_last);
                sent_count++;
            end
        end
    endtask

    // receiver holds off while points keep coming, so the input backs up
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            test_random_polylines(30);
        join
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("polyline_delta_char_encoder_unit_tb: FAIL");
        $finish;
    end

    initial begin
        last_lat = '0;
        last_lng = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_flag_combinations();
        test_value_extremes();
        test_known_polyline();

        tx_idle_pct = 0;  rx_stall_pct = 0;
        test_random_polylines(95);
        tx_idle_pct = 79; rx_stall_pct = 0;
        test_random_polylines(95);
        tx_idle_pct = 0;  rx_stall_pct = 79;
        test_random_polylines(95);
        tx_idle_pct = 29; rx_stall_pct = 29;
        test_random_polylines(95);
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("polyline_delta_char_encoder_unit_tb: PASS");
        else
            $display("polyline_delta_char_encoder_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
